// File: hw/rtl/tb8c_pkg.sv
// Package for the eight-bit textbook CPU step block: command codes,
// opcode codes, field widths and the byte rotate helper.
// No dependencies.
`default_nettype none

package tb8c_pkg;

  localparam int CmdW  = 2;
  localparam int ByteW = 8;
  localparam int NibW  = 4;
  localparam int MemDepth = 256;
  localparam int RegDepth = 16;

  localparam logic [CmdW-1:0] CMD_WR_MEM = 2'd0;
  localparam logic [CmdW-1:0] CMD_RD_MEM = 2'd1;
  localparam logic [CmdW-1:0] CMD_RD_REG = 2'd2;
  localparam logic [CmdW-1:0] CMD_EXEC   = 2'd3;

  localparam logic [NibW-1:0] OP_LOAD_DIR = 4'h1;
  localparam logic [NibW-1:0] OP_LOAD_IMM = 4'h2;
  localparam logic [NibW-1:0] OP_STORE    = 4'h3;
  localparam logic [NibW-1:0] OP_MOVE     = 4'h4;
  localparam logic [NibW-1:0] OP_ADD      = 4'h5;
  localparam logic [NibW-1:0] OP_OR       = 4'h7;
  localparam logic [NibW-1:0] OP_AND      = 4'h8;
  localparam logic [NibW-1:0] OP_XOR      = 4'h9;
  localparam logic [NibW-1:0] OP_ROTATE   = 4'hA;
  localparam logic [NibW-1:0] OP_JUMP_EQ  = 4'hB;
  localparam logic [NibW-1:0] OP_HALT     = 4'hC;

  // Rotate a byte right by 0..7 places.
  function automatic logic [ByteW-1:0] rotr8(input logic [ByteW-1:0] v,
                                             input logic [2:0] n);
    logic [2*ByteW-1:0] d;
    d = {v, v} >> n;
    return d[ByteW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tb8c_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module tb8c_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/textbook_8bit_cpu_step.sv
// Eight-bit textbook CPU, one command per input word. Top level; uses
// tb8c_pkg and three tb8c_ram instances (main memory, two register file copies).
`default_nettype none

// Each input word carries a command in s_axis_tuser: write a memory byte,
// read a memory byte, read a register, or execute one 16-bit instruction
// fetched big-endian at the program counter. Each command returns exactly
// one output word with the read byte, the program counter afterwards and
// what the step wrote. Main memory is a 256 x 8 RAM with one read port, so
// an execute steps through S_A to S_D (fetch high byte, fetch low byte,
// operand and register reads, then writeback); a memory write ends in S_A
// and a memory or register read in S_B. The register file is held twice so the
// two source operands come out in the same cycle. Per-entry valid bits
// make memory and registers read as zero after reset, with no clearing
// pass. A one-word input buffer takes the next word while the current one
// executes, and a registered output stage holds a finished word; a command
// waits in its last cycle only while that output word is not yet taken.
module textbook_8bit_cpu_step
  import tb8c_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // addr[7:0], wdata[15:8]
  input  wire logic [1:0]  s_axis_tuser,  // cmd[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_data[7:0], pc[15:8], halted[16], opcode[20:17], reg_written[21],
  // reg_index[25:22], reg_value[33:26], mem_written[34], mem_addr[42:35], zero pad
  output logic [47:0]      m_axis_tdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_A    = 3'd1;
  localparam logic [2:0] S_B    = 3'd2;
  localparam logic [2:0] S_C    = 3'd3;
  localparam logic [2:0] S_D    = 3'd4;

  logic [2:0] state, state_next;

  // Input buffer and current command.
  logic             buf_full;
  logic [CmdW-1:0]  buf_cmd;
  logic [ByteW-1:0] buf_addr, buf_wdata;
  logic [CmdW-1:0]  cur_cmd;
  logic [ByteW-1:0] cur_addr, cur_wdata;

  logic [ByteW-1:0] pc;
  logic [ByteW-1:0] hi_q, lo_q;

  // Memory side.
  logic [MemDepth-1:0] mem_vld;
  logic                mem_rd_ok;
  logic [ByteW-1:0]    mem_raddr, mem_waddr, mem_wdata, mem_raw, mem_byte;
  logic                mem_we;

  // Register file side.
  logic [RegDepth-1:0] rf_vld;
  logic                rfa_ok, rfb_ok;
  logic [NibW-1:0]     rf_raddr_a, rf_raddr_b, rf_waddr;
  logic [ByteW-1:0]    rf_wdata, rfa_raw, rfb_raw, reg_a, reg_b;
  logic                rf_we;

  // Decode and execute.
  logic [NibW-1:0]  op_cur, r_cur, x_cur, y_cur;
  logic [ByteW-1:0] lo_cur;
  logic             ex_rw, ex_mw;
  logic [NibW-1:0]  ex_ridx;
  logic [ByteW-1:0] ex_rval, ex_pc;

  logic final_st, out_free, fire, start, s_accept;

  // Output stage.
  logic             out_valid;
  logic [ByteW-1:0] out_read_data, out_pc, out_reg_value, out_mem_addr;
  logic             out_halted, out_reg_written, out_mem_written;
  logic [NibW-1:0]  out_opcode, out_reg_index;

  assign s_axis_tready = !buf_full;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_mem_addr, out_mem_written, out_reg_value,
                          out_reg_index, out_reg_written, out_opcode,
                          out_halted, out_pc, out_read_data};

  // Read data counts only if the entry was written since reset.
  assign mem_byte = mem_rd_ok ? mem_raw : '0;
  assign reg_a    = rfa_ok ? rfa_raw : '0;
  assign reg_b    = rfb_ok ? rfb_raw : '0;

  // Instruction fields: low byte comes straight off the RAM in S_C.
  assign op_cur = hi_q[7:4];
  assign r_cur  = hi_q[3:0];
  assign lo_cur = (state == S_C) ? mem_byte : lo_q;
  assign x_cur  = lo_cur[7:4];
  assign y_cur  = lo_cur[3:0];

  // Last cycle of each command; hold there while the output word waits.
  always_comb begin
    final_st = 1'b0;
    unique case (state)
      S_A:     final_st = (cur_cmd == CMD_WR_MEM);
      S_B:     final_st = (cur_cmd == CMD_RD_MEM) || (cur_cmd == CMD_RD_REG);
      S_D:     final_st = 1'b1;
      default: final_st = 1'b0;
    endcase
  end

  assign out_free = !out_valid || m_axis_tready;
  assign fire     = final_st && out_free;
  assign start    = buf_full && ((state == S_IDLE) || fire);

  always_comb begin
    state_next = state;
    if (fire) begin
      state_next = buf_full ? S_A : S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  state_next = buf_full ? S_A : S_IDLE;
        S_A:     state_next = (cur_cmd == CMD_WR_MEM) ? S_A : S_B;
        S_B:     state_next = (cur_cmd == CMD_EXEC) ? S_C : S_B;
        S_C:     state_next = S_D;
        S_D:     state_next = S_D;
        default: state_next = S_IDLE;
      endcase
    end
  end

  // Memory read address: command address for reads, else the fetch
  // sequence pc, pc+1, then the direct-load operand at the low byte.
  always_comb begin
    mem_raddr = pc;
    unique case (state)
      S_A:     mem_raddr = (cur_cmd == CMD_RD_MEM) ? cur_addr : pc;
      S_B:     mem_raddr = (cur_cmd == CMD_EXEC) ? pc + 8'd1 : cur_addr;
      S_C:     mem_raddr = lo_cur;
      S_D:     mem_raddr = lo_cur;
      default: mem_raddr = pc;
    endcase
  end

  // Register read ports: port A serves X for moves and ALU ops, else R;
  // port B serves Y, or R0 for the compare of a conditional jump.
  always_comb begin
    if ((state == S_A) || (state == S_B)) begin
      rf_raddr_a = cur_addr[3:0];
      rf_raddr_b = cur_addr[3:0];
    end else begin
      rf_raddr_a = r_cur;
      if ((op_cur == OP_MOVE) || (op_cur == OP_ADD) || (op_cur == OP_OR) ||
          (op_cur == OP_AND) || (op_cur == OP_XOR)) begin
        rf_raddr_a = x_cur;
      end
      rf_raddr_b = (op_cur == OP_JUMP_EQ) ? '0 : y_cur;
    end
  end

  // Execute, valid in S_D.
  always_comb begin
    ex_rw   = 1'b0;
    ex_mw   = 1'b0;
    ex_ridx = '0;
    ex_rval = '0;
    ex_pc   = pc + 8'd2;
    unique case (op_cur)
      OP_LOAD_DIR: begin ex_rw = 1'b1; ex_ridx = r_cur; ex_rval = mem_byte; end
      OP_LOAD_IMM: begin ex_rw = 1'b1; ex_ridx = r_cur; ex_rval = lo_cur; end
      OP_STORE:    begin ex_mw = 1'b1; end
      OP_MOVE:     begin ex_rw = 1'b1; ex_ridx = y_cur; ex_rval = reg_a; end
      OP_ADD:      begin ex_rw = 1'b1; ex_ridx = r_cur; ex_rval = reg_a + reg_b; end
      OP_OR:       begin ex_rw = 1'b1; ex_ridx = r_cur; ex_rval = reg_a | reg_b; end
      OP_AND:      begin ex_rw = 1'b1; ex_ridx = r_cur; ex_rval = reg_a & reg_b; end
      OP_XOR:      begin ex_rw = 1'b1; ex_ridx = r_cur; ex_rval = reg_a ^ reg_b; end
      OP_ROTATE: begin
        ex_rw   = 1'b1;
        ex_ridx = r_cur;
        ex_rval = rotr8(reg_a, y_cur[2:0]);
      end
      OP_JUMP_EQ: begin
        if (reg_a == reg_b) begin
          ex_pc = lo_cur;
        end
      end
      OP_HALT: ex_pc = '0;
      default: ex_pc = pc + 8'd2;
    endcase
  end

  // Writes happen only in the completing cycle, so a stall never repeats one.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = cur_wdata;
    if ((state == S_A) && (cur_cmd == CMD_WR_MEM)) begin
      mem_we = fire;
    end else if (state == S_D) begin
      mem_we    = fire && ex_mw;
      mem_waddr = lo_cur;
      mem_wdata = reg_a;
    end
  end

  assign rf_we    = fire && (state == S_D) && ex_rw;
  assign rf_waddr = ex_ridx;
  assign rf_wdata = ex_rval;

  tb8c_ram #(.WIDTH(ByteW), .DEPTH(MemDepth)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_raw)
  );

  tb8c_ram #(.WIDTH(ByteW), .DEPTH(RegDepth)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr_a),
    .rdata (rfa_raw)
  );

  tb8c_ram #(.WIDTH(ByteW), .DEPTH(RegDepth)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_raddr_b),
    .rdata (rfb_raw)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      buf_full  <= 1'b0;
      out_valid <= 1'b0;
      pc        <= '0;
      mem_vld   <= '0;
      rf_vld    <= '0;
      mem_rd_ok <= 1'b0;
      rfa_ok    <= 1'b0;
      rfb_ok    <= 1'b0;
    end else begin
      state     <= state_next;
      mem_rd_ok <= mem_vld[mem_raddr];
      rfa_ok    <= rf_vld[rf_raddr_a];
      rfb_ok    <= rf_vld[rf_raddr_b];
      if (mem_we) begin
        mem_vld[mem_waddr] <= 1'b1;
      end
      if (rf_we) begin
        rf_vld[rf_waddr] <= 1'b1;
      end
      if (start) begin
        buf_full <= 1'b0;
      end else if (s_accept) begin
        buf_full <= 1'b1;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (fire && (state == S_D)) begin
        pc <= ex_pc;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_accept) begin
      buf_cmd   <= s_axis_tuser;
      buf_addr  <= s_axis_tdata[7:0];
      buf_wdata <= s_axis_tdata[15:8];
    end
    if (start) begin
      cur_cmd   <= buf_cmd;
      cur_addr  <= buf_addr;
      cur_wdata <= buf_wdata;
    end
    if (state == S_B) begin
      hi_q <= mem_byte;
    end
    if (state == S_C) begin
      lo_q <= mem_byte;
    end
    if (fire) begin
      out_read_data   <= '0;
      out_pc          <= pc;
      out_halted      <= 1'b0;
      out_opcode      <= '0;
      out_reg_written <= 1'b0;
      out_reg_index   <= '0;
      out_reg_value   <= '0;
      out_mem_written <= 1'b0;
      out_mem_addr    <= '0;
      if (cur_cmd == CMD_RD_MEM) begin
        out_read_data <= mem_byte;
      end else if (cur_cmd == CMD_RD_REG) begin
        out_read_data <= reg_a;
      end else if (cur_cmd == CMD_EXEC) begin
        out_pc          <= ex_pc;
        out_halted      <= (ex_pc == '0);
        out_opcode      <= op_cur;
        out_reg_written <= ex_rw;
        out_reg_index   <= ex_ridx;
        out_reg_value   <= ex_rval;
        out_mem_written <= ex_mw;
        out_mem_addr    <= ex_mw ? lo_cur : '0;
      end
    end
  end

  // Decode and operand cycles belong to execute commands only.
  a_exec_only: assert property (@(posedge clk) disable iff (rst)
    (state == S_C) || (state == S_D) |-> cur_cmd == CMD_EXEC)
    else $error("decode state reached by a non-execute command");

  // The operand cycle never stalls.
  a_c_to_d: assert property (@(posedge clk) disable iff (rst)
    state == S_C |=> state == S_D)
    else $error("operand cycle did not advance to writeback");

  // A halted report always carries a zero program counter.
  a_halt_pc: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_halted |-> out_pc == '0)
    else $error("halted reported with nonzero program counter");

  // One step never writes both a register and memory.
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_reg_written && out_mem_written))
    else $error("register and memory written by one step");

  // Memory is written only by a write command or an execute writeback.
  a_mem_we: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> ((state == S_A) && (cur_cmd == CMD_WR_MEM)) || (state == S_D))
    else $error("memory written outside a write or writeback cycle");

endmodule

`default_nettype wire

// File: sim/tb_textbook_8bit_cpu_step.sv
// Self-checking testbench for textbook_8bit_cpu_step: directed table, then random
// programs; every output word is checked field by field against a local CPU model
// or a typed answer. Depends on tb8c_pkg and the textbook_8bit_cpu_step RTL.
`default_nettype none

module tb_textbook_8bit_cpu_step
  import tb8c_pkg::*;
();

  localparam int CycleLimit  = 200000;
  localparam int RandomWords = 1100;
  localparam int QuietTail   = 150;
  localparam int TailCycles  = 12;

  // One output word, packed to match m_axis_tdata[42:0] (last field lowest).
  typedef struct packed {
    logic [ByteW-1:0] mem_addr;
    logic             mem_written;
    logic [ByteW-1:0] reg_value;
    logic [NibW-1:0]  reg_index;
    logic             reg_written;
    logic [NibW-1:0]  opcode;
    logic             halted;
    logic [ByteW-1:0] pc;
    logic [ByteW-1:0] read_data;
  } step_result_t;

  // One row of the directed table; typed rows carry a hand-written answer.
  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [ByteW-1:0] addr;
    logic [ByteW-1:0] wdata;
    bit               typed;
    step_result_t     exp;
  } stim_row_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;  // addr[7:0], wdata[15:8]
  logic [1:0]  s_axis_tuser  = '0;  // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // read_data[7:0], pc[15:8], halted[16], opcode[20:17], reg_written[21],
  // reg_index[25:22], reg_value[33:26], mem_written[34], mem_addr[42:35], zero pad
  logic [47:0] m_axis_tdata;

  // Local copy of the machine state, advanced once per accepted input word.
  logic [ByteW-1:0] mem_model [0:MemDepth-1];
  logic [ByteW-1:0] reg_model [0:RegDepth-1];
  logic [ByteW-1:0] pc_model;

  step_result_t pending_steps [$];
  stim_row_t    dir_rows [$];
  int           mismatch_count = 0;
  int           word_count     = 0;
  int           cycle_count    = 0;
  bit           stalls_on      = 1'b1;

  textbook_8bit_cpu_step dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort on a hang: no run that works comes anywhere near this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** textbook_8bit_cpu_step: FAILED **");
      $finish;
    end
  end

  // Run one command on the local model and return the word it must produce.
  function automatic step_result_t cpu_step(input logic [CmdW-1:0] cmd,
                                            input logic [ByteW-1:0] addr,
                                            input logic [ByteW-1:0] wdata);
    step_result_t     r;
    logic [ByteW-1:0] hi, lo, nxt, rx, ry, v;
    logic [NibW-1:0]  rn, xn, yn;
    r = '0;
    case (cmd)
      CMD_WR_MEM: mem_model[addr] = wdata;
      CMD_RD_MEM: r.read_data = mem_model[addr];
      CMD_RD_REG: r.read_data = reg_model[addr[NibW-1:0]];
      default: begin
        // Fetch big-endian at pc; the second byte wraps past 0xFF.
        nxt = pc_model + 8'd1;
        hi  = mem_model[pc_model];
        lo  = mem_model[nxt];
        rn  = hi[3:0];
        xn  = lo[7:4];
        yn  = lo[3:0];
        rx  = reg_model[xn];
        ry  = reg_model[yn];
        r.opcode = hi[7:4];
        pc_model = pc_model + 8'd2;
        case (hi[7:4])
          OP_LOAD_DIR: begin
            r.reg_written = 1'b1; r.reg_index = rn; r.reg_value = mem_model[lo];
          end
          OP_LOAD_IMM: begin
            r.reg_written = 1'b1; r.reg_index = rn; r.reg_value = lo;
          end
          OP_STORE: begin
            r.mem_written = 1'b1; r.mem_addr = lo;
          end
          OP_MOVE: begin
            r.reg_written = 1'b1; r.reg_index = yn; r.reg_value = rx;
          end
          OP_ADD: begin
            r.reg_written = 1'b1; r.reg_index = rn; r.reg_value = rx + ry;
          end
          OP_OR: begin
            r.reg_written = 1'b1; r.reg_index = rn; r.reg_value = rx | ry;
          end
          OP_AND: begin
            r.reg_written = 1'b1; r.reg_index = rn; r.reg_value = rx & ry;
          end
          OP_XOR: begin
            r.reg_written = 1'b1; r.reg_index = rn; r.reg_value = rx ^ ry;
          end
          OP_ROTATE: begin
            // Rotate amount is the Y nibble modulo 8; zero leaves the value.
            v = reg_model[rn];
            repeat (yn[2:0]) v = {v[0], v[7:1]};
            r.reg_written = 1'b1; r.reg_index = rn; r.reg_value = v;
          end
          OP_JUMP_EQ: begin
            if (reg_model[rn] == reg_model[0]) pc_model = lo;
          end
          OP_HALT: pc_model = '0;
          default: ;  // unused opcodes only advance the counter
        endcase
        if (r.mem_written) mem_model[r.mem_addr] = reg_model[rn];
        if (r.reg_written) reg_model[r.reg_index] = r.reg_value;
        r.halted = (pc_model == '0);
      end
    endcase
    r.pc = pc_model;
    return r;
  endfunction

  function automatic step_result_t typed_result(
      input logic [7:0] rd, input logic [7:0] pc, input logic halted,
      input logic [3:0] op, input logic rw, input logic [3:0] ridx,
      input logic [7:0] rval, input logic mw, input logic [7:0] maddr);
    step_result_t r;
    r.read_data   = rd;
    r.pc          = pc;
    r.halted      = halted;
    r.opcode      = op;
    r.reg_written = rw;
    r.reg_index   = ridx;
    r.reg_value   = rval;
    r.mem_written = mw;
    r.mem_addr    = maddr;
    return r;
  endfunction

  task automatic add_row(input logic [CmdW-1:0] cmd, input logic [7:0] addr,
                         input logic [7:0] wdata, input bit typed,
                         input step_result_t exp);
    stim_row_t row;
    row.cmd   = cmd;
    row.addr  = addr;
    row.wdata = wdata;
    row.typed = typed;
    row.exp   = exp;
    dir_rows.push_back(row);
  endtask

  // Present one input word at the falling edge, hold it until accepted,
  // then queue the typed answer or what the model says it must return.
  // A random hold-off with valid low may come first while stalls are on.
  task automatic send_word(input logic [CmdW-1:0] cmd, input logic [7:0] addr,
                           input logic [7:0] wdata, input bit typed,
                           input step_result_t typed_exp);
    step_result_t pred;
    int           gap;
    if (stalls_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {wdata, addr};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pred = cpu_step(cmd, addr, wdata);
    pending_steps.push_back(typed ? typed_exp : pred);
    word_count++;
  endtask

  // Drop valid and hold off until every queued word has come back.
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk);
  endtask

  function automatic bit field_ok(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Receiver: stall in random bursts, none while stalls are off.
  int stall_left = 0;
  always @(negedge clk) begin
    if (!stalls_on) begin
      stall_left = 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Output checker: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    step_result_t got, want;
    bit           ok;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_steps.size() == 0) begin
        $display("%0t: unexpected output word %0h, expected none", $time, m_axis_tdata);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_steps.pop_front();
        got  = m_axis_tdata[42:0];
        ok   = 1'b1;
        ok &= field_ok("read_data",   want.read_data,       got.read_data);
        ok &= field_ok("pc",          want.pc,              got.pc);
        ok &= field_ok("halted",      8'(want.halted),      8'(got.halted));
        ok &= field_ok("opcode",      8'(want.opcode),      8'(got.opcode));
        ok &= field_ok("reg_written", 8'(want.reg_written), 8'(got.reg_written));
        ok &= field_ok("reg_index",   8'(want.reg_index),   8'(got.reg_index));
        ok &= field_ok("reg_value",   want.reg_value,       got.reg_value);
        ok &= field_ok("mem_written", 8'(want.mem_written), 8'(got.mem_written));
        ok &= field_ok("mem_addr",    want.mem_addr,        got.mem_addr);
        ok &= field_ok("pad",         8'h00,                8'(m_axis_tdata[47:43]));
        if (!ok) mismatch_count = mismatch_count + 1;
      end
    end
  end

  initial begin
    int               pick;
    bit               pressed;
    logic [NibW-1:0]  op, rn;
    logic [ByteW-1:0] at, operand;

    for (int i = 0; i < MemDepth; i++) mem_model[i] = '0;
    for (int i = 0; i < RegDepth; i++) reg_model[i] = '0;
    pc_model = '0;
    pressed  = 1'b0;

    // Directed table. Reads after reset, an empty fetch, the immediate load
    // and the halt have answers typed in; the rest go through the model.
    add_row(CMD_RD_MEM, 8'hFF, 8'h00, 1'b1,
            typed_result(8'h00, 8'h00, 1'b0, 4'h0, 1'b0, 4'h0, 8'h00, 1'b0, 8'h00));
    // Register read uses only the low nibble of addr.
    add_row(CMD_RD_REG, 8'hF3, 8'hFF, 1'b1,
            typed_result(8'h00, 8'h00, 1'b0, 4'h0, 1'b0, 4'h0, 8'h00, 1'b0, 8'h00));
    // Zeroed memory decodes as a no-op: only the counter moves.
    add_row(CMD_EXEC,   8'h00, 8'h00, 1'b1,
            typed_result(8'h00, 8'h02, 1'b0, 4'h0, 1'b0, 4'h0, 8'h00, 1'b0, 8'h00));
    add_row(CMD_WR_MEM, 8'h02, 8'h2F, 1'b0, '0);
    add_row(CMD_WR_MEM, 8'h03, 8'hFF, 1'b0, '0);
    add_row(CMD_EXEC,   8'h00, 8'h00, 1'b1,
            typed_result(8'h00, 8'h04, 1'b0, OP_LOAD_IMM, 1'b1, 4'hF, 8'hFF, 1'b0, 8'h00));
    // Rotate by the largest amount, seven places.
    add_row(CMD_WR_MEM, 8'h04, 8'hAF, 1'b0, '0);
    add_row(CMD_WR_MEM, 8'h05, 8'h07, 1'b0, '0);
    add_row(CMD_EXEC,   8'hFF, 8'hFF, 1'b0, '0);
    // Store to the top address.
    add_row(CMD_WR_MEM, 8'h06, 8'h3F, 1'b0, '0);
    add_row(CMD_WR_MEM, 8'h07, 8'hFF, 1'b0, '0);
    add_row(CMD_EXEC,   8'h00, 8'h00, 1'b0, '0);
    // Jump taken (R0 against itself) to 0xFE, the last word before the counter wraps.
    add_row(CMD_WR_MEM, 8'h08, 8'hB0, 1'b0, '0);
    add_row(CMD_WR_MEM, 8'h09, 8'hFE, 1'b0, '0);
    add_row(CMD_EXEC,   8'h00, 8'h00, 1'b0, '0);
    // Load direct at 0xFE reads its operand from 0xFF; counter wraps to 0.
    add_row(CMD_WR_MEM, 8'hFE, 8'h1E, 1'b0, '0);
    add_row(CMD_EXEC,   8'h00, 8'h00, 1'b0, '0);
    add_row(CMD_WR_MEM, 8'h00, 8'hC0, 1'b0, '0);
    add_row(CMD_EXEC,   8'h00, 8'h00, 1'b1,
            typed_result(8'h00, 8'h00, 1'b1, OP_HALT, 1'b0, 4'h0, 8'h00, 1'b0, 8'h00));
    add_row(CMD_RD_MEM, 8'hFF, 8'h00, 1'b0, '0);
    add_row(CMD_RD_REG, 8'h0E, 8'h00, 1'b0, '0);
    add_row(CMD_WR_MEM, 8'h01, 8'h00, 1'b0, '0);

    // Hold reset, then release it at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_word(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].wdata,
                dir_rows[i].typed, dir_rows[i].exp);

    // Random part: mostly write an instruction at the counter and run it,
    // mixed with bare executes, reads and stray memory writes.
    while (word_count < dir_rows.size() + RandomWords) begin
      if (word_count >= dir_rows.size() + RandomWords - QuietTail) stalls_on = 1'b0;
      else if ($urandom_range(0, 59) == 0) stalls_on = !stalls_on;

      // Once, halfway, let the block run dry before going on.
      if (!pressed && word_count >= dir_rows.size() + RandomWords / 2) begin
        pressed = 1'b1;
        drain();
      end

      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        op      = 4'($urandom_range(0, 15));
        rn      = 4'($urandom_range(0, 15));
        operand = 8'($urandom_range(0, 255));
        // Compare R0 with itself now and then so jumps get taken.
        if (op == OP_JUMP_EQ && $urandom_range(0, 2) == 0) rn = '0;
        at = pc_model;
        send_word(CMD_WR_MEM, at, {op, rn}, 1'b0, '0);
        send_word(CMD_WR_MEM, at + 8'd1, operand, 1'b0, '0);
        send_word(CMD_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'b0, '0);
      end else if (pick < 70) begin
        send_word(CMD_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'b0, '0);
      end else if (pick < 80) begin
        send_word(CMD_RD_REG, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'b0, '0);
      end else if (pick < 90) begin
        send_word(CMD_RD_MEM, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'b0, '0);
      end else begin
        send_word(CMD_WR_MEM, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  1'b0, '0);
      end
    end

    // Wait for the last words, then a few cycles more for any stray output.
    drain();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_steps.size() == 0) begin
      $display("** textbook_8bit_cpu_step: PASSED **");
    end else begin
      $display("** textbook_8bit_cpu_step: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
